[rtl/core/json_syntax_validator_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the JSON syntax validator.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message. The checks vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef JSON_SYNTAX_VALIDATOR_UNIT_ASSERT_SVH
`define JSON_SYNTAX_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define JSV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define JSV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JSV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/jsv_pkg.sv]
// ---------------------------------------------------------------------------
// jsv_pkg
// Types, character codes and helper functions of the JSON syntax validator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsv_pkg;

  // Parser position within the grammar.
  typedef enum logic [4:0] {
    M_TOP,
    M_ARR_FIRST,
    M_VALUE,
    M_OBJ_FIRST,
    M_OBJ_KEY,
    M_COLON,
    M_AFTER,
    M_STR_VAL,
    M_STR_KEY,
    M_ESC_VAL,
    M_ESC_KEY,
    M_HEX_VAL,
    M_HEX_KEY,
    M_LITERAL,
    M_N_SIGN,
    M_N_ZERO,
    M_N_INT,
    M_N_DOT,
    M_N_FRAC,
    M_N_EXP,
    M_N_EXPSIGN,
    M_N_EXPDIG
  } mode_e;

  // Error codes as reported on the result channel.
  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SYNTAX,
    ERR_OVERFLOW,
    ERR_UNENDED
  } err_e;

  // Literal being matched.
  typedef enum logic [1:0] {
    LIT_TRUE,
    LIT_FALSE,
    LIT_NULL
  } lit_e;

  localparam int unsigned DEPTH_LIMIT_W = 7;
  localparam logic [DEPTH_LIMIT_W-1:0] DEPTH_LIMIT_RST = 7'd64;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UP_A   = "A";
  localparam logic [7:0] CH_UP_E   = "E";
  localparam logic [7:0] CH_UP_F   = "F";
  localparam logic [7:0] CH_LO_A   = "a";
  localparam logic [7:0] CH_LO_B   = "b";
  localparam logic [7:0] CH_LO_E   = "e";
  localparam logic [7:0] CH_LO_F   = "f";
  localparam logic [7:0] CH_LO_L   = "l";
  localparam logic [7:0] CH_LO_N   = "n";
  localparam logic [7:0] CH_LO_R   = "r";
  localparam logic [7:0] CH_LO_S   = "s";
  localparam logic [7:0] CH_LO_T   = "t";
  localparam logic [7:0] CH_LO_U   = "u";

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= CH_LO_A) && (b <= CH_LO_F)) ||
           ((b >= CH_UP_A) && (b <= CH_UP_F));
  endfunction

  // Length of each literal in characters.
  function automatic logic [2:0] lit_len(input lit_e kind);
    logic [2:0] len;
    unique case (kind)
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      LIT_NULL:  len = 3'd4;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Expected character at a given position of a literal.
  function automatic logic [7:0] lit_char(input lit_e kind, input logic [2:0] step);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (kind)
      LIT_TRUE: begin
        unique case (step)
          3'd0:    ch = CH_LO_T;
          3'd1:    ch = CH_LO_R;
          3'd2:    ch = CH_LO_U;
          3'd3:    ch = CH_LO_E;
          default: ch = CH_NUL;
        endcase
      end
      LIT_FALSE: begin
        unique case (step)
          3'd0:    ch = CH_LO_F;
          3'd1:    ch = CH_LO_A;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_S;
          3'd4:    ch = CH_LO_E;
          default: ch = CH_NUL;
        endcase
      end
      LIT_NULL: begin
        unique case (step)
          3'd0:    ch = CH_LO_N;
          3'd1:    ch = CH_LO_U;
          3'd2:    ch = CH_LO_L;
          3'd3:    ch = CH_LO_L;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/core/json_syntax_validator_unit.sv]
// ---------------------------------------------------------------------------
// json_syntax_validator_unit
// Checks a JSON document, one byte per item, and reports a verdict on the
// item marked last.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid_i/in_ready_o | in_byte_value_i, in_last_byte_i
//  out      | output    | out_valid_o/out_ready_i | out_is_valid_o, out_error_kind_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_depth_limit_i
//
// One item per cycle sustained. An item sits in the input register, where
// the parser state is updated, and a verdict then sits in the result
// register. The top of the nesting stack is kept in a flip-flop and
// the entry below it is read ahead from the stack RAM, so closing brackets
// back to back need no stall. The input only stalls when a last item
// finds the result register still full. Reset clears the parser and sets the
// depth limit to 64; the stack RAM needs no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "json_syntax_validator_unit_assert.svh"

module json_syntax_validator_unit
  import jsv_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Document bytes
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_value_i,
  input  wire logic       in_last_byte_i,
  // Verdicts
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_is_valid_o,
  output logic [1:0]      out_error_kind_o,
  // Depth limit register
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [DEPTH_LIMIT_W-1:0] cfg_depth_limit_i
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CW = (DW > DEPTH_LIMIT_W) ? DW : DEPTH_LIMIT_W;
  localparam logic [CW-1:0] MAX_DEPTH_C = CW'(MAX_DEPTH);

  // Input register
  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic        last_q;

  // Parser state
  mode_e                    mode_q, mode_d, mode_p, mode_eff;
  logic [DW-1:0]            depth_q, depth_d, depth_p;
  logic                     top_q, top_d, top_p;
  lit_e                     lit_kind_q, lit_kind_d, lit_kind_p;
  logic [2:0]               lit_step_q, lit_step_d, lit_step_p;
  logic [2:0]               hex_left_q, hex_left_d, hex_left_p;
  err_e                     err_q, err_d, err_p, err_fin;
  logic                     ebz_q, ebz_d;
  logic [DEPTH_LIMIT_W-1:0] limit_q;

  // Result register
  logic        out_vld_q, out_vld_d;
  logic        out_ok_q;
  err_e        out_err_q;

  // Handshake and stack signals
  logic          out_free;
  logic          proc_fire;
  logic          run;
  logic          num_end;
  logic          can_open;
  logic          take_start;
  logic          take_close;
  logic          push;
  logic          push_bit;
  logic          want_obj;
  logic          below_bit;
  logic [DW:0]   rd_idx;
  logic [AW-1:0] rd_addr;
  mode_e         fin_mode;
  logic [DW-1:0] fin_depth;
  err_e          fin_base;
  logic          complete;
  logic          do_finish;

  // Item handshake: a non-last item always proceeds, a last item waits for
  // room in the result register.
  assign out_free   = !out_vld_q || out_ready_i;
  assign proc_fire  = in_vld_q && (!last_q || out_free);
  assign in_ready_o = !in_vld_q || proc_fire;
  assign cfg_ready_o = 1'b1;

  // Parsing runs only on live, non-zero bytes with no error latched.
  assign run = !ebz_q && (byte_q != CH_NUL) && (err_q == ERR_NONE);

  // A finished number hands the terminating byte to the after-value rules.
  always_comb begin
    unique case (mode_q)
      M_N_ZERO:   num_end = !((byte_q == CH_DOT) || (byte_q == CH_LO_E) ||
                              (byte_q == CH_UP_E));
      M_N_INT:    num_end = !(is_digit(byte_q) || (byte_q == CH_DOT) ||
                              (byte_q == CH_LO_E) || (byte_q == CH_UP_E));
      M_N_FRAC:   num_end = !(is_digit(byte_q) || (byte_q == CH_LO_E) ||
                              (byte_q == CH_UP_E));
      M_N_EXPDIG: num_end = !is_digit(byte_q);
      default:    num_end = 1'b0;
    endcase
    mode_eff = num_end ? M_AFTER : mode_q;
  end

  // Opening is allowed below both the register limit and the stack size.
  assign can_open = (CW'(depth_q) < CW'(limit_q)) && (CW'(depth_q) < MAX_DEPTH_C);
  assign want_obj = (byte_q == CH_RBRACE);

  // Next parser state for one byte.
  always_comb begin
    mode_p     = mode_eff;
    depth_p    = depth_q;
    top_p      = top_q;
    lit_kind_p = lit_kind_q;
    lit_step_p = lit_step_q;
    hex_left_p = hex_left_q;
    err_p      = err_q;
    take_start = 1'b0;
    take_close = 1'b0;
    push       = 1'b0;
    push_bit   = 1'b0;
    if (!run) begin
      mode_p = mode_q;
    end else begin
      unique case (mode_eff)
        M_TOP, M_VALUE: begin
          take_start = !is_ws(byte_q);
        end
        M_ARR_FIRST: begin
          if (!is_ws(byte_q)) begin
            if (byte_q == CH_RBRACK) take_close = 1'b1;
            else take_start = 1'b1;
          end
        end
        M_OBJ_FIRST, M_OBJ_KEY: begin
          if (!is_ws(byte_q)) begin
            if (byte_q == CH_RBRACE && mode_eff == M_OBJ_FIRST) take_close = 1'b1;
            else if (byte_q == CH_QUOTE) mode_p = M_STR_KEY;
            else err_p = ERR_SYNTAX;
          end
        end
        M_COLON: begin
          if (!is_ws(byte_q)) begin
            if (byte_q == CH_COLON) mode_p = M_VALUE;
            else err_p = ERR_SYNTAX;
          end
        end
        M_AFTER: begin
          if (!is_ws(byte_q)) begin
            if (depth_q == '0) err_p = ERR_SYNTAX;
            else if (byte_q == CH_COMMA) mode_p = top_q ? M_OBJ_KEY : M_VALUE;
            else if (byte_q == CH_RBRACK || byte_q == CH_RBRACE) take_close = 1'b1;
            else err_p = ERR_SYNTAX;
          end
        end
        M_STR_VAL, M_STR_KEY: begin
          if (byte_q == CH_QUOTE) begin
            mode_p = (mode_eff == M_STR_KEY) ? M_COLON : M_AFTER;
          end else if (byte_q == CH_BSLASH) begin
            mode_p = (mode_eff == M_STR_KEY) ? M_ESC_KEY : M_ESC_VAL;
          end
        end
        M_ESC_VAL, M_ESC_KEY: begin
          if (byte_q == CH_QUOTE || byte_q == CH_BSLASH || byte_q == CH_SLASH ||
              byte_q == CH_LO_B || byte_q == CH_LO_F || byte_q == CH_LO_N ||
              byte_q == CH_LO_R || byte_q == CH_LO_T) begin
            mode_p = (mode_eff == M_ESC_KEY) ? M_STR_KEY : M_STR_VAL;
          end else if (byte_q == CH_LO_U) begin
            hex_left_p = 3'd4;
            mode_p = (mode_eff == M_ESC_KEY) ? M_HEX_KEY : M_HEX_VAL;
          end else begin
            err_p = ERR_SYNTAX;
          end
        end
        M_HEX_VAL, M_HEX_KEY: begin
          if (!is_hex(byte_q) || hex_left_q == 3'd0) begin
            err_p = ERR_SYNTAX;
          end else begin
            hex_left_p = hex_left_q - 3'd1;
            if (hex_left_q == 3'd1) begin
              mode_p = (mode_eff == M_HEX_KEY) ? M_STR_KEY : M_STR_VAL;
            end
          end
        end
        M_LITERAL: begin
          if (lit_step_q >= lit_len(lit_kind_q) ||
              byte_q != lit_char(lit_kind_q, lit_step_q)) begin
            err_p = ERR_SYNTAX;
          end else begin
            lit_step_p = lit_step_q + 3'd1;
            if (lit_step_p == lit_len(lit_kind_q)) mode_p = M_AFTER;
          end
        end
        M_N_SIGN: begin
          if (byte_q == CH_ZERO) mode_p = M_N_ZERO;
          else if (is_digit(byte_q)) mode_p = M_N_INT;
          else err_p = ERR_SYNTAX;
        end
        M_N_ZERO, M_N_INT, M_N_FRAC, M_N_EXPDIG: begin
          // Only continuing bytes land here; terminators went to M_AFTER.
          if (byte_q == CH_DOT) mode_p = M_N_DOT;
          else if (byte_q == CH_LO_E || byte_q == CH_UP_E) mode_p = M_N_EXP;
        end
        M_N_DOT: begin
          if (is_digit(byte_q)) mode_p = M_N_FRAC;
          else err_p = ERR_SYNTAX;
        end
        M_N_EXP: begin
          if (byte_q == CH_PLUS || byte_q == CH_MINUS) mode_p = M_N_EXPSIGN;
          else if (is_digit(byte_q)) mode_p = M_N_EXPDIG;
          else err_p = ERR_SYNTAX;
        end
        M_N_EXPSIGN: begin
          if (is_digit(byte_q)) mode_p = M_N_EXPDIG;
          else err_p = ERR_SYNTAX;
        end
        default: err_p = ERR_SYNTAX;
      endcase

      // Start of a new value.
      if (take_start) begin
        priority if (byte_q == CH_LBRACE || byte_q == CH_LBRACK) begin
          if (!can_open) begin
            err_p = ERR_OVERFLOW;
          end else begin
            push     = 1'b1;
            push_bit = (byte_q == CH_LBRACE);
            depth_p  = depth_q + DW'(1);
            top_p    = push_bit;
            mode_p   = push_bit ? M_OBJ_FIRST : M_ARR_FIRST;
          end
        end else if (byte_q == CH_QUOTE) begin
          mode_p = M_STR_VAL;
        end else if (byte_q == CH_LO_T || byte_q == CH_LO_F || byte_q == CH_LO_N) begin
          lit_kind_p = (byte_q == CH_LO_T) ? LIT_TRUE :
                       (byte_q == CH_LO_F) ? LIT_FALSE : LIT_NULL;
          lit_step_p = 3'd1;
          mode_p     = M_LITERAL;
        end else if (byte_q == CH_MINUS) begin
          mode_p = M_N_SIGN;
        end else if (byte_q == CH_ZERO) begin
          mode_p = M_N_ZERO;
        end else if (is_digit(byte_q)) begin
          mode_p = M_N_INT;
        end else begin
          err_p = ERR_SYNTAX;
        end
      end

      // Closing bracket: must match the open container.
      if (take_close) begin
        if (depth_q == '0 || top_q != want_obj) begin
          err_p = ERR_SYNTAX;
        end else begin
          depth_p = depth_q - DW'(1);
          top_p   = below_bit;
          mode_p  = M_AFTER;
        end
      end
    end
  end

  // End-of-document judgement, on a zero byte or on the last byte.
  always_comb begin
    fin_mode  = (byte_q == CH_NUL) ? mode_q : mode_p;
    fin_depth = (byte_q == CH_NUL) ? depth_q : depth_p;
    fin_base  = (byte_q == CH_NUL) ? err_q : err_p;
    complete  = ((fin_mode == M_AFTER) || (fin_mode == M_N_ZERO) ||
                 (fin_mode == M_N_INT) || (fin_mode == M_N_FRAC) ||
                 (fin_mode == M_N_EXPDIG)) && (fin_depth == '0);
    if (fin_base != ERR_NONE) err_fin = fin_base;
    else if (complete) err_fin = ERR_NONE;
    else err_fin = ERR_UNENDED;
    do_finish = !ebz_q && ((byte_q == CH_NUL) || last_q);
  end

  // State update; the last byte returns the parser to its start state.
  always_comb begin
    mode_d     = mode_q;
    depth_d    = depth_q;
    top_d      = top_q;
    lit_kind_d = lit_kind_q;
    lit_step_d = lit_step_q;
    hex_left_d = hex_left_q;
    err_d      = err_q;
    ebz_d      = ebz_q;
    if (proc_fire) begin
      if (last_q) begin
        mode_d     = M_TOP;
        depth_d    = '0;
        lit_kind_d = LIT_TRUE;
        lit_step_d = 3'd0;
        hex_left_d = 3'd0;
        err_d      = ERR_NONE;
        ebz_d      = 1'b0;
      end else begin
        mode_d     = mode_p;
        depth_d    = depth_p;
        top_d      = top_p;
        lit_kind_d = lit_kind_p;
        lit_step_d = lit_step_p;
        hex_left_d = hex_left_p;
        err_d      = do_finish ? err_fin : err_p;
        ebz_d      = ebz_q || (byte_q == CH_NUL);
      end
    end
  end

  // Input register control.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) in_vld_d = in_valid_i;
  end

  // Result register control.
  always_comb begin
    out_vld_d = out_vld_q;
    if (proc_fire && last_q) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      mode_q     <= M_TOP;
      depth_q    <= '0;
      lit_kind_q <= LIT_TRUE;
      lit_step_q <= 3'd0;
      hex_left_q <= 3'd0;
      err_q      <= ERR_NONE;
      ebz_q      <= 1'b0;
      limit_q    <= DEPTH_LIMIT_RST;
    end else begin
      in_vld_q   <= in_vld_d;
      out_vld_q  <= out_vld_d;
      mode_q     <= mode_d;
      depth_q    <= depth_d;
      lit_kind_q <= lit_kind_d;
      lit_step_q <= lit_step_d;
      hex_left_q <= hex_left_d;
      err_q      <= err_d;
      ebz_q      <= ebz_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_depth_limit_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_value_i;
      last_q <= in_last_byte_i;
    end
    if (proc_fire && last_q) begin
      out_err_q <= do_finish ? err_fin : err_q;
      out_ok_q  <= ((do_finish ? err_fin : err_q) == ERR_NONE);
    end
  end

  // Nesting stack. The RAM always reads the entry below the next top.
  assign rd_idx  = {1'b0, depth_d} - (DW + 1)'(2);
  assign rd_addr = rd_idx[AW-1:0];

  jsv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (proc_fire && push && !last_q),
    .wr_addr_i (depth_q[AW-1:0]),
    .wr_data_i (push_bit),
    .rd_addr_i (rd_addr),
    .rd_data_o (below_bit)
  );

  assign out_valid_o      = out_vld_q;
  assign out_is_valid_o   = out_ok_q;
  assign out_error_kind_o = out_err_q;

  // Checks on the parser and the result register.
  `JSV_ASSERT_IMP(a_verdict_fields, clk_i, rst_ni, out_valid_o,
                  out_is_valid_o == (out_error_kind_o == ERR_NONE),
                  "verdict flag disagrees with error kind")
  `JSV_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, 1'b1,
                  CW'(depth_q) <= MAX_DEPTH_C,
                  "nesting depth beyond stack size")
  `JSV_ASSERT_IMP(a_push_in_range, clk_i, rst_ni, proc_fire && push,
                  can_open && (CW'(depth_q) < CW'(limit_q)),
                  "stack push above the depth limit")
  `JSV_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, proc_fire && last_q,
                  (depth_q == '0) && (mode_q == M_TOP) && (err_q == ERR_NONE) && !ebz_q,
                  "parser not back at start after the last item")
  `JSV_ASSERT_IMP(a_result_source, clk_i, rst_ni, out_valid_o && !$past(out_valid_o),
                  $past(proc_fire && last_q),
                  "result appeared without a last item")

endmodule

`default_nettype wire

[rtl/core/jsv_ram.sv]
// ---------------------------------------------------------------------------
// jsv_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsv_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, updated every cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[tb/json_verdict_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON verdict checker
// Watches the byte, verdict and depth limit channels of the validator. Every
// accepted byte goes through a parser of its own; the verdict it forms on a
// last byte is queued and compared, field by field, with the next verdict
// that the block hands over. The number of failures and of verdicts still
// awaited are given to the testbench top.
// ---------------------------------------------------------------------------
module json_verdict_checker
  import jsv_pkg::*;
#(
  parameter int unsigned NEST_MAX = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic [7:0]               in_byte_value_i,
  input  wire logic                     in_last_byte_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic                     out_is_valid_i,
  input  wire logic [1:0]               out_error_kind_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [DEPTH_LIMIT_W-1:0] cfg_depth_limit_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic ok;
    err_e kind;
  } verdict_t;

  // Parser copy and the depth limit as last written.
  logic [DEPTH_LIMIT_W-1:0] limit_q;
  mode_e                    pmode;
  bit                       obj_stack [NEST_MAX];
  int unsigned              nest;
  lit_e                     lit_kind;
  int unsigned              lit_pos;
  int unsigned              hex_left;
  err_e                     err_q;
  bit                       zero_seen;

  verdict_t verdict_q [$];

  function automatic bit blank_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic bit dec_char(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic bit hex_char(input logic [7:0] b);
    return dec_char(b) || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic string literal_word(input lit_e k);
    case (k)
      LIT_TRUE:  return "true";
      LIT_FALSE: return "false";
      default:   return "null";
    endcase
  endfunction

  function automatic void restart_parse();
    pmode     = M_TOP;
    nest      = 0;
    lit_kind  = LIT_TRUE;
    lit_pos   = 0;
    hex_left  = 0;
    err_q     = ERR_NONE;
    zero_seen = 1'b0;
  endfunction

  // Opening a container at the effective limit is an overflow.
  function automatic void open_level(input bit is_obj);
    int unsigned eff;
    eff = (limit_q < NEST_MAX) ? limit_q : NEST_MAX;
    if (nest >= eff) begin
      err_q = ERR_OVERFLOW;
    end else begin
      obj_stack[nest] = is_obj;
      nest++;
      pmode = is_obj ? M_OBJ_FIRST : M_ARR_FIRST;
    end
  endfunction

  // A closing bracket must match the innermost open container.
  function automatic void close_level(input logic [7:0] b);
    if (nest == 0 || obj_stack[nest-1] != (b == CH_RBRACE)) begin
      err_q = ERR_SYNTAX;
    end else begin
      nest--;
      pmode = M_AFTER;
    end
  endfunction

  function automatic void begin_value(input logic [7:0] b);
    if (b == CH_LBRACE) begin
      open_level(1'b1);
    end else if (b == CH_LBRACK) begin
      open_level(1'b0);
    end else if (b == CH_QUOTE) begin
      pmode = M_STR_VAL;
    end else if (b == CH_LO_T || b == CH_LO_F || b == CH_LO_N) begin
      lit_kind = (b == CH_LO_T) ? LIT_TRUE : (b == CH_LO_F) ? LIT_FALSE : LIT_NULL;
      lit_pos  = 1;
      pmode    = M_LITERAL;
    end else if (b == CH_MINUS) begin
      pmode = M_N_SIGN;
    end else if (b == CH_ZERO) begin
      pmode = M_N_ZERO;
    end else if (dec_char(b)) begin
      pmode = M_N_INT;
    end else begin
      err_q = ERR_SYNTAX;
    end
  endfunction

  // One byte through the grammar. A number ends on the first byte that cannot
  // extend it, and that byte is then parsed again after the value.
  function automatic void parse_byte(input logic [7:0] b);
    bit    again;
    bit    key;
    string word;
    for (int pass = 0; pass < 2; pass++) begin
      again = 1'b0;
      key   = (pmode == M_STR_KEY) || (pmode == M_ESC_KEY) || (pmode == M_HEX_KEY);
      case (pmode)
        M_TOP, M_VALUE: begin
          if (!blank_char(b)) begin_value(b);
        end
        M_ARR_FIRST: begin
          if (!blank_char(b)) begin
            if (b == CH_RBRACK) close_level(b);
            else begin_value(b);
          end
        end
        M_OBJ_FIRST, M_OBJ_KEY: begin
          if (!blank_char(b)) begin
            if (b == CH_RBRACE && pmode == M_OBJ_FIRST) close_level(b);
            else if (b == CH_QUOTE) pmode = M_STR_KEY;
            else err_q = ERR_SYNTAX;
          end
        end
        M_COLON: begin
          if (!blank_char(b)) begin
            if (b == CH_COLON) pmode = M_VALUE;
            else err_q = ERR_SYNTAX;
          end
        end
        M_AFTER: begin
          if (!blank_char(b)) begin
            if (nest == 0) err_q = ERR_SYNTAX;
            else if (b == CH_COMMA) pmode = obj_stack[nest-1] ? M_OBJ_KEY : M_VALUE;
            else if (b == CH_RBRACK || b == CH_RBRACE) close_level(b);
            else err_q = ERR_SYNTAX;
          end
        end
        M_STR_VAL, M_STR_KEY: begin
          if (b == CH_QUOTE) pmode = key ? M_COLON : M_AFTER;
          else if (b == CH_BSLASH) pmode = key ? M_ESC_KEY : M_ESC_VAL;
        end
        M_ESC_VAL, M_ESC_KEY: begin
          if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_LO_B ||
              b == CH_LO_F || b == CH_LO_N || b == CH_LO_R || b == CH_LO_T) begin
            pmode = key ? M_STR_KEY : M_STR_VAL;
          end else if (b == CH_LO_U) begin
            hex_left = 4;
            pmode    = key ? M_HEX_KEY : M_HEX_VAL;
          end else begin
            err_q = ERR_SYNTAX;
          end
        end
        M_HEX_VAL, M_HEX_KEY: begin
          if (!hex_char(b) || hex_left == 0) begin
            err_q = ERR_SYNTAX;
          end else begin
            hex_left--;
            if (hex_left == 0) pmode = key ? M_STR_KEY : M_STR_VAL;
          end
        end
        M_LITERAL: begin
          word = literal_word(lit_kind);
          if (lit_pos >= word.len() || b != 8'(word[lit_pos])) begin
            err_q = ERR_SYNTAX;
          end else begin
            lit_pos++;
            if (lit_pos == word.len()) pmode = M_AFTER;
          end
        end
        M_N_SIGN: begin
          if (b == CH_ZERO) pmode = M_N_ZERO;
          else if (dec_char(b)) pmode = M_N_INT;
          else err_q = ERR_SYNTAX;
        end
        M_N_ZERO, M_N_INT: begin
          if (dec_char(b) && pmode == M_N_INT) begin
          end else if (b == CH_DOT) begin
            pmode = M_N_DOT;
          end else if (b == CH_LO_E || b == CH_UP_E) begin
            pmode = M_N_EXP;
          end else begin
            pmode = M_AFTER;
            again = 1'b1;
          end
        end
        M_N_DOT: begin
          if (dec_char(b)) pmode = M_N_FRAC;
          else err_q = ERR_SYNTAX;
        end
        M_N_FRAC: begin
          if (dec_char(b)) begin
          end else if (b == CH_LO_E || b == CH_UP_E) begin
            pmode = M_N_EXP;
          end else begin
            pmode = M_AFTER;
            again = 1'b1;
          end
        end
        M_N_EXP: begin
          if (b == CH_PLUS || b == CH_MINUS) pmode = M_N_EXPSIGN;
          else if (dec_char(b)) pmode = M_N_EXPDIG;
          else err_q = ERR_SYNTAX;
        end
        M_N_EXPSIGN: begin
          if (dec_char(b)) pmode = M_N_EXPDIG;
          else err_q = ERR_SYNTAX;
        end
        M_N_EXPDIG: begin
          if (!dec_char(b)) begin
            pmode = M_AFTER;
            again = 1'b1;
          end
        end
        default: err_q = ERR_SYNTAX;
      endcase
      if (!again) break;
    end
  endfunction

  // End of input: a number that may stop here counts as complete, and only
  // one finished top-level value makes a valid document.
  function automatic void end_document();
    if (err_q == ERR_NONE) begin
      if (pmode == M_N_ZERO || pmode == M_N_INT || pmode == M_N_FRAC ||
          pmode == M_N_EXPDIG) begin
        pmode = M_AFTER;
      end
      if (!(pmode == M_AFTER && nest == 0)) err_q = ERR_UNENDED;
    end
  endfunction

  // A zero byte fixes the verdict; everything after it up to the last byte
  // is ignored, and after an error only the last byte still matters.
  function automatic void take_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    if (!zero_seen) begin
      if (b == CH_NUL) begin
        end_document();
        zero_seen = 1'b1;
      end else if (err_q == ERR_NONE) begin
        parse_byte(b);
      end
    end
    if (last) begin
      if (!zero_seen) end_document();
      v.ok   = (err_q == ERR_NONE);
      v.kind = err_q;
      verdict_q.push_back(v);
      restart_parse();
    end
  endfunction

  // Sample all three channels at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      limit_q = DEPTH_LIMIT_RST;
      foreach (obj_stack[i]) obj_stack[i] = 1'b0;
      restart_parse();
      verdict_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_depth_limit_i;
      if (in_valid_i && in_ready_i) take_byte(in_byte_value_i, in_last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with none awaited: is_valid=%0d error_kind=%0d",
                   $time, out_is_valid_i, out_error_kind_i);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (out_is_valid_i !== want.ok) begin
            $display("%0t: is_valid expected %0d, got %0d", $time, want.ok, out_is_valid_i);
            fail_count_o++;
          end
          if (out_error_kind_i !== want.kind) begin
            $display("%0t: error_kind expected %0d, got %0d", $time, want.kind,
                     out_error_kind_i);
            fail_count_o++;
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

[tb/json_syntax_validator_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON syntax validator testbench
// Sends short directed documents and then random ones, mostly well-formed
// with random content and some spoilt or pure noise, under several depth
// limits and three idling regimes. A checker beside the block predicts and
// compares every verdict; this top only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module json_syntax_validator_unit_tb;
  import jsv_pkg::*;

  localparam int unsigned NEST_MAX = 64;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               in_byte_value_i   = 8'h00;
  logic                     in_last_byte_i    = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i       = 1'b0;
  logic                     out_is_valid_o;
  logic [1:0]               out_error_kind_o;
  logic                     cfg_valid_i       = 1'b0;
  logic                     cfg_ready_o;
  logic [DEPTH_LIMIT_W-1:0] cfg_depth_limit_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cur_limit = 64;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [7:0]  doc_bytes [$];

  json_syntax_validator_unit #(
    .MAX_DEPTH(NEST_MAX)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_value_i   (in_byte_value_i),
    .in_last_byte_i    (in_last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_is_valid_o    (out_is_valid_o),
    .out_error_kind_o  (out_error_kind_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_depth_limit_i (cfg_depth_limit_i)
  );

  json_verdict_checker #(
    .NEST_MAX(NEST_MAX)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_byte_value_i   (in_byte_value_i),
    .in_last_byte_i    (in_last_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_is_valid_i    (out_is_valid_o),
    .out_error_kind_i  (out_error_kind_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_depth_limit_i (cfg_depth_limit_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Clock; reset is released by the stimulus block.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // The verdict receiver stalls at random.
  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Document building.
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_gap();
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) doc_bytes.push_back(pick_char(" \t\n\r"));
    end
  endfunction

  // A string with plain characters, raw bytes and escapes.
  function automatic void add_string();
    logic [7:0] raw;
    doc_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          do raw = 8'($urandom_range(1, 255)); while (raw == CH_QUOTE || raw == CH_BSLASH);
          doc_bytes.push_back(raw);
        end
        1: begin
          doc_bytes.push_back(CH_BSLASH);
          doc_bytes.push_back(pick_char("\"\\/bfnrt"));
        end
        2: begin
          doc_bytes.push_back(CH_BSLASH);
          doc_bytes.push_back(CH_LO_U);
          repeat (4) doc_bytes.push_back(pick_char("0123456789abcdefABCDEF"));
        end
        default: doc_bytes.push_back(pick_char("abcxyz019 _-"));
      endcase
    end
    doc_bytes.push_back(CH_QUOTE);
  endfunction

  // A number in the standard form, with optional fraction and exponent.
  function automatic void add_number();
    if ($urandom_range(0, 1) == 0) doc_bytes.push_back(CH_MINUS);
    if ($urandom_range(0, 2) == 0) begin
      doc_bytes.push_back(CH_ZERO);
    end else begin
      doc_bytes.push_back(8'($urandom_range(8'h31, 8'h39)));
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
    if ($urandom_range(0, 2) == 0) begin
      doc_bytes.push_back(CH_DOT);
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
    if ($urandom_range(0, 2) == 0) begin
      doc_bytes.push_back(pick_char("eE"));
      if ($urandom_range(0, 1) == 0) doc_bytes.push_back(pick_char("+-"));
      repeat ($urandom_range(1, 2)) doc_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
  endfunction

  function automatic void add_scalar();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 2))
          0:       put_text("true");
          1:       put_text("false");
          default: put_text("null");
        endcase
      end
      1, 2:    add_string();
      default: add_number();
    endcase
  endfunction

  // A well-formed document built without recursion. When diving, containers
  // are opened until the nesting goal is reached.
  function automatic void build_doc(input int nest_goal, input bit dive);
    bit kinds [$];
    bit fresh [$];
    bit want_value;
    bit opening;
    int budget;
    budget     = $urandom_range(1, 8);
    want_value = 1'b1;
    add_gap();
    forever begin
      if (want_value) begin
        opening = (kinds.size() < nest_goal) &&
                  (dive || (budget > 0 && $urandom_range(0, 2) == 0));
        if (opening) begin
          kinds.push_back(1'($urandom_range(0, 1)));
          fresh.push_back(1'b1);
          doc_bytes.push_back(kinds[kinds.size()-1] ? CH_LBRACE : CH_LBRACK);
          if (kinds.size() >= nest_goal) dive = 1'b0;
        end else begin
          add_scalar();
        end
        want_value = 1'b0;
        budget--;
        add_gap();
      end else if (kinds.size() == 0) begin
        break;
      end else if (!dive && (budget <= 0 || $urandom_range(0, 3) == 0)) begin
        doc_bytes.push_back(kinds[kinds.size()-1] ? CH_RBRACE : CH_RBRACK);
        void'(kinds.pop_back());
        void'(fresh.pop_back());
        add_gap();
      end else begin
        if (!fresh[fresh.size()-1]) begin
          doc_bytes.push_back(CH_COMMA);
          add_gap();
        end
        fresh[fresh.size()-1] = 1'b0;
        if (kinds[kinds.size()-1]) begin
          add_string();
          add_gap();
          doc_bytes.push_back(CH_COLON);
          add_gap();
        end
        want_value = 1'b1;
      end
    end
  endfunction

  // Breaks a document in one place: a random or zero byte, a cut, an extra
  // byte or a missing one.
  function automatic void spoil_doc();
    int pos;
    pos = $urandom_range(0, doc_bytes.size() - 1);
    case ($urandom_range(0, 4))
      0: doc_bytes[pos] = 8'($urandom_range(0, 255));
      1: while (doc_bytes.size() > pos + 1) void'(doc_bytes.pop_back());
      2: doc_bytes.insert(pos, pick_char("{}[]:,\"\\.eE+-0tu"));
      3: if (doc_bytes.size() > 1) doc_bytes.delete(pos);
      default: doc_bytes[pos] = CH_NUL;
    endcase
  endfunction

  // Byte sender. The sender idles at random before each item and keeps
  // valid high while the item waits.
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_value_i <= b;
    in_last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_doc();
    foreach (doc_bytes[i]) send_item(doc_bytes[i], i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  // Waits until every verdict has come, then lets the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [DEPTH_LIMIT_W-1:0] v);
    cfg_valid_i       <= 1'b1;
    cfg_depth_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_limit = 32'(v);
  endtask

  // Random documents until the byte goal of the phase is met.
  task automatic run_docs(input int byte_goal);
    int sent;
    int eff;
    int goal;
    int roll;
    bit dive;
    sent = 0;
    eff  = (cur_limit < NEST_MAX) ? cur_limit : NEST_MAX;
    while (sent < byte_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) doc_bytes.push_back(8'($urandom_range(0, 255)));
          else doc_bytes.push_back(pick_char("{}[]\":,-0.9eE tfnu\\"));
        end
      end else begin
        dive = ($urandom_range(0, 11) == 0);
        if (dive) goal = ($urandom_range(0, 1) == 0) ? eff + 1 : $urandom_range(1, eff + 1);
        else goal = $urandom_range(0, 3);
        build_doc(goal, dive);
        if (roll >= 75) spoil_doc();
      end
      sent += doc_bytes.size();
      send_doc();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 78;

    // Directed documents: a lone number, whitespace only, a mismatched
    // bracket, an error followed by more bytes, raw bytes in a string, a zero
    // byte mid-document, a zero byte alone and a small object.
    put_text("0");
    send_doc();
    put_text(" ");
    send_doc();
    put_text("[}");
    send_doc();
    put_text("tx1");
    send_doc();
    doc_bytes = '{CH_QUOTE, 8'hFF, 8'h01, CH_QUOTE};
    send_doc();
    doc_bytes = '{CH_LBRACK, CH_NUL, 8'h78};
    send_doc();
    doc_bytes = '{CH_NUL};
    send_doc();
    put_text("{\"a\":1e-2}");
    send_doc();

    // Random phases under changing depth limits and idling regimes.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 78;
      end else if (phase < 6) begin
        send_idle_pct = 78;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase > 0) begin
        drain();
        case (phase)
          1:       write_limit(7'd1);
          2:       write_limit(7'd0);
          3:       write_limit(7'd127);
          4:       write_limit(7'd2);
          5:       write_limit(7'd64);
          6:       write_limit(7'($urandom_range(3, 63)));
          default: write_limit(7'd65);
        endcase
      end
      run_docs(210);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
